### hdl/utfd_pkg.sv
// Shared constants, types and table functions for the Unix time to FAT date/time unit.
package utfd_pkg;

	// Divisors for the three time-of-day division phases
	localparam int unsigned SECS_PER_DAY = 24 * 60 * 60;
	localparam logic [16:0] DIV_DAY  = 17'(SECS_PER_DAY);
	localparam logic [16:0] DIV_HOUR = 17'd3600;
	localparam logic [16:0] DIV_MIN  = 17'd60;

	// Reciprocals of the odd divisor parts: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
	localparam logic [25:0] RECIP_DAY  = 26'd50903317;  // ceil(2^35 / 675)
	localparam logic [13:0] RECIP_HOUR = 14'd9321;      // ceil(2^21 / 225)
	localparam logic [10:0] RECIP_MIN  = 11'd1093;      // ceil(2^14 / 15)

	// Quotient steps before the remainder step of each phase
	localparam logic [5:0] STEPS_DAY  = 6'd1;
	localparam logic [5:0] STEPS_HOUR = 6'd1;
	localparam logic [5:0] STEPS_MIN  = 6'd1;

	// Calendar constants; year counter is an offset from 1970
	localparam logic [7:0] YEAR_FAT_BASE  = 8'(1980 - 1970);
	localparam logic [1:0] EPOCH_MOD4     = 2'(1970 % 4);
	localparam logic [8:0] DAYS_YEAR      = 9'd365;
	localparam logic [8:0] DAYS_LEAP_YEAR = 9'd366;
	localparam logic [3:0] LAST_MONTH     = 4'd11;
	localparam logic [3:0] MONTH_FEB      = 4'd1;

	// Division phase
	typedef enum logic [1:0] {
		PH_DAY  = 2'd0,
		PH_HOUR = 2'd1,
		PH_MIN  = 2'd2
	} div_phase_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       cfg_we;
		logic       load;
		logic       div_step;
		logic       div_next;
		div_phase_t phase;
		logic       year_step;
		logic       month_step;
		logic       emit;
	} utfd_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic year_fit;
		logic month_fit;
	} utfd_sts_t;

	// Divisor of a phase
	function automatic logic [16:0] phase_divisor(input div_phase_t phase);
		logic [16:0] d;
		unique case (phase)
			PH_DAY:  d = DIV_DAY;
			PH_HOUR: d = DIV_HOUR;
			PH_MIN:  d = DIV_MIN;
			default: d = DIV_MIN;
		endcase
		return d;
	endfunction

	// Every fourth year is a leap year, 2100 included
	function automatic logic is_leap(input logic [7:0] year_off);
		return (2'(year_off[1:0] + EPOCH_MOD4)) == 2'd0;
	endfunction

	// Days in a month, month index from zero
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month) inside
			MONTH_FEB:                  len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
			default:                    len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

### hdl/utfd_dp.sv
// Datapath: zone register, reciprocal-multiply divider, year and month walkers, result register.
module utfd_dp
	import utfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  utfd_cmd_t   cmd,
	output utfd_sts_t   sts,
	input  logic [11:0] cfg_data,
	input  logic [31:0] in_secs,
	output logic [31:0] out_data
);

	logic [11:0] zone_q;
	logic [31:0] num_q;
	logic [15:0] quo_q;
	logic [15:0] days_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [4:0]  half_q;
	logic [7:0]  year_q;
	logic [3:0]  month_q;
	logic [31:0] out_q;

	logic signed [18:0] zone_prod;
	logic [31:0]        adj;
	logic [50:0]        day_prod;
	logic [26:0]        hour_prod;
	logic [20:0]        min_prod;
	logic [15:0]        quo_next;
	logic [31:0]        quo_mul;
	logic [31:0]        rem_next;
	logic               leap;
	logic [8:0]         ylen;
	logic [4:0]         mlen;
	logic [6:0]         year_fat;

	// Zone offset in seconds, then adjusted count
	assign zone_prod = $signed({{7{zone_q[11]}}, zone_q}) * 19'sd60;
	assign adj       = in_secs - {{13{zone_prod[18]}}, zone_prod};

	// Quotient by reciprocal multiplication, power-of-two factor shifted out first
	assign day_prod  = num_q[31:7] * RECIP_DAY;
	assign hour_prod = num_q[16:4] * RECIP_HOUR;
	assign min_prod  = num_q[11:2] * RECIP_MIN;

	always_comb begin
		case (cmd.phase)
			PH_DAY:  quo_next = day_prod[50:35];
			PH_HOUR: quo_next = {10'd0, hour_prod[26:21]};
			PH_MIN:  quo_next = {9'd0, min_prod[20:14]};
			default: quo_next = 16'd0;
		endcase
	end

	// Remainder of the current phase
	assign quo_mul  = {16'd0, quo_q} * {15'd0, phase_divisor(cmd.phase)};
	assign rem_next = num_q - quo_mul;

	// Calendar lengths for the walkers
	assign leap = is_leap(year_q);
	assign ylen = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
	assign mlen = month_len(month_q, leap);

	assign sts.year_fit  = days_q < {7'd0, ylen};
	assign sts.month_fit = (days_q < {11'd0, mlen}) || (month_q == LAST_MONTH);

	assign year_fat = (year_q < YEAR_FAT_BASE) ? 7'd0 : 7'(year_q - YEAR_FAT_BASE);

	// Zone register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= 12'd0;
		end else if (cmd.cfg_we) begin
			zone_q <= cfg_data;
		end
	end

	// Divider, walkers and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= adj;
		end
		if (cmd.div_step) begin
			quo_q <= quo_next;
		end
		if (cmd.div_next) begin
			case (cmd.phase)
				PH_DAY: begin
					days_q  <= quo_q;
					num_q   <= rem_next;
					year_q  <= 8'd0;
					month_q <= 4'd0;
				end
				PH_HOUR: begin
					hour_q <= quo_q[4:0];
					num_q  <= rem_next;
				end
				PH_MIN: begin
					minute_q <= quo_q[5:0];
					half_q   <= rem_next[5:1];
				end
				default: begin
				end
			endcase
		end
		if (cmd.year_step) begin
			days_q <= days_q - {7'd0, ylen};
			year_q <= year_q + 8'd1;
		end
		if (cmd.month_step) begin
			days_q  <= days_q - {11'd0, mlen};
			month_q <= month_q + 4'd1;
		end
		if (cmd.emit) begin
			out_q <= {year_fat, 4'(month_q + 4'd1), 5'(days_q[4:0] + 5'd1),
				hour_q, minute_q, half_q};
		end
	end

	assign out_data = out_q;

endmodule

### hdl/utfd_ctrl.sv
// Controller: sequences accept, division phases, year and month walks and result hand-off.
module utfd_ctrl
	import utfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  utfd_sts_t sts,
	output utfd_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DIVIDE = 5'b00010,
		ST_YEAR   = 5'b00100,
		ST_MONTH  = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t     state_q;
	div_phase_t phase_q;
	logic [5:0] cnt_q;
	logic       out_valid_q;

	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	// Decode commands from the state
	always_comb begin
		cmd        = '0;
		cmd.phase  = phase_q;
		cmd.cfg_we = (state_q == ST_IDLE) && cfg_valid;
		unique case (state_q)
			ST_IDLE:   cmd.load       = in_valid;
			ST_DIVIDE: begin
				cmd.div_step = cnt_q != 6'd0;
				cmd.div_next = cnt_q == 6'd0;
			end
			ST_YEAR:   cmd.year_step  = !sts.year_fit;
			ST_MONTH:  cmd.month_step = !sts.month_fit;
			ST_EMIT:   cmd.emit       = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_DAY;
			cnt_q   <= 6'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIVIDE;
						phase_q <= PH_DAY;
						cnt_q   <= STEPS_DAY;
					end
				end
				ST_DIVIDE: begin
					if (cnt_q != 6'd0) begin
						cnt_q <= cnt_q - 6'd1;
					end else begin
						case (phase_q)
							PH_DAY: begin
								phase_q <= PH_HOUR;
								cnt_q   <= STEPS_HOUR;
							end
							PH_HOUR: begin
								phase_q <= PH_MIN;
								cnt_q   <= STEPS_MIN;
							end
							default: state_q <= ST_YEAR;
						endcase
					end
				end
				ST_YEAR: begin
					if (sts.year_fit) state_q <= ST_MONTH;
				end
				ST_MONTH: begin
					if (sts.month_fit) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### hdl/unix_time_to_fat_datetime_unit.sv
// Top level of the Unix time to FAT date/time unit.
//
// Input stream (s_axis): one 32-bit Unix seconds count per item. Output
// stream (m_axis): one FAT date/time item per input item, in order.
// Config channel (cfg_*): 12-bit signed zone offset in minutes west of GMT,
// taken while the unit is idle; it is subtracted as minutes times sixty.
//
// One item is worked on at a time. After an item is taken the unit divides
// by reciprocal multiplication in three phases (day, hour, minute), each a
// quotient step and then a remainder step, then walks years from 1970 one
// per cycle and months one per cycle. The next item is taken once the
// result has gone to the output register.
//
// The result sits in an output register: a new item is taken while it waits.
// If the receiver stalls, a finished item holds in its final state until
// the register frees. Reset returns the unit to idle, drops any pending
// result and clears the zone offset to zero.
module unix_time_to_fat_datetime_unit
	import utfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] unix_seconds
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] half_seconds, [10:5] minute_value, [15:11] hour_value,
	// [20:16] day_of_month, [24:21] month_number, [31:25] year_since_1980
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data        // zone_minutes_west
);

	utfd_cmd_t cmd;
	utfd_sts_t sts;

	utfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	utfd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_data (cfg_data),
		.in_secs  (s_axis_tdata),
		.out_data (m_axis_tdata)
	);

endmodule
